// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/bdc_pkg.sv =====
`default_nettype none
package bdc_pkg;

  localparam int TIME_WIDTH_DEF = 48;
  localparam int CFG_WIDTH      = 24;
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int EVENT_WIDTH    = 3;

  localparam logic                 PRESS_POL_RST  = 1'b0;
  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST   = 24'd20000;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RST = 24'd1000000;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_PRESS_POL  = 2'd0,
    CFG_DEBOUNCE   = 2'd1,
    CFG_LONG_PRESS = 2'd2
  } cfg_idx_t;

  typedef enum logic [EVENT_WIDTH-1:0] {
    EV_UNKNOWN  = 3'd0,
    EV_ACTIVE   = 3'd1,
    EV_INACTIVE = 3'd2,
    EV_CLICK    = 3'd3,
    EV_LONG     = 3'd4
  } event_t;

  typedef struct packed {
    logic pressed;
    logic armed;
  } bdc_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bdc_core.sv =====
`default_nettype none
module bdc_core #(
  parameter int TIME_WIDTH = bdc_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           step,
  input  wire logic                           pin_level,
  input  wire logic [TIME_WIDTH-1:0]          time_now,
  input  wire logic                           press_pol,
  input  wire logic [bdc_pkg::CFG_WIDTH-1:0]  debounce_time,
  input  wire logic [bdc_pkg::CFG_WIDTH-1:0]  long_press_time,
  output bdc_pkg::event_t                     event_code,
  output bdc_pkg::bdc_status_t                status
);

  logic [TIME_WIDTH-1:0] edge_time_r, edge_time_nxt;
  logic                  pressed_r, pressed_nxt;
  logic                  armed_r, armed_nxt;

  logic                  act;
  logic                  later;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  past_db;
  logic                  past_lp;

  assign act     = (pin_level == press_pol);
  assign later   = (time_now > edge_time_r);
  assign elapsed = time_now - edge_time_r;
  assign past_db = later &&
                   (elapsed > {{(TIME_WIDTH-bdc_pkg::CFG_WIDTH){1'b0}}, debounce_time});
  assign past_lp = later &&
                   (elapsed > {{(TIME_WIDTH-bdc_pkg::CFG_WIDTH){1'b0}}, long_press_time});

  always_comb begin
    edge_time_nxt = edge_time_r;
    pressed_nxt   = pressed_r;
    armed_nxt     = armed_r;
    event_code    = bdc_pkg::EV_UNKNOWN;
    priority if (!pressed_r) begin
      if (act) begin
        edge_time_nxt = time_now;
        pressed_nxt   = 1'b1;
        armed_nxt     = 1'b1;
      end else if (past_db) begin
        event_code = bdc_pkg::EV_INACTIVE;
      end
    end else if (act) begin
      if (armed_r && past_lp) begin
        armed_nxt  = 1'b0;
        event_code = bdc_pkg::EV_LONG;
      end else if (past_db) begin
        event_code = bdc_pkg::EV_ACTIVE;
      end
    end else begin
      if (armed_r && past_db) begin
        event_code = bdc_pkg::EV_CLICK;
      end
      edge_time_nxt = time_now;
      pressed_nxt   = 1'b0;
      armed_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_time_r <= '0;
      pressed_r   <= 1'b0;
      armed_r     <= 1'b0;
    end else if (step) begin
      edge_time_r <= edge_time_nxt;
      pressed_r   <= pressed_nxt;
      armed_r     <= armed_nxt;
    end
  end

  assign status.pressed = pressed_r;
  assign status.armed   = armed_r;

endmodule
`default_nettype wire

// ===== hw/rtl/button_debounce_click_long_press_top.sv =====
// Path: an input transfer is captured in the input register, then its result in the result register.
// Throughput: one scan per cycle while out_ready does not stall the output; each scan yields exactly one event.
// Timing path: one TIME_WIDTH subtract plus two compares against the debounce/hold times, beside a time_now compare.
// Reset: synchronous, active low; edge time and flags clear, config returns to defaults.
`default_nettype none
`include "assert_macros.svh"
module button_debounce_click_long_press_top #(
  parameter int TIME_WIDTH = bdc_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic                               in_pin_level,
  input  wire logic [TIME_WIDTH-1:0]              in_time_now,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic [bdc_pkg::EVENT_WIDTH-1:0]    out_event_code,
  input  wire logic                               cfg_we,
  input  wire logic [bdc_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [bdc_pkg::CFG_WIDTH-1:0]      cfg_wdata
);

  logic                          press_pol_r;
  logic [bdc_pkg::CFG_WIDTH-1:0] debounce_time_r;
  logic [bdc_pkg::CFG_WIDTH-1:0] long_press_time_r;

  logic                          s1_valid_r;
  logic                          s1_level_r;
  logic [TIME_WIDTH-1:0]         s1_time_r;

  logic                          out_valid_r;
  logic [bdc_pkg::EVENT_WIDTH-1:0] out_event_r;

  logic                          advance;
  logic                          fire;
  logic                          in_xfer;
  bdc_pkg::event_t               evt;
  bdc_pkg::bdc_status_t          status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_pol_r       <= bdc_pkg::PRESS_POL_RST;
      debounce_time_r   <= bdc_pkg::DEBOUNCE_RST;
      long_press_time_r <= bdc_pkg::LONG_PRESS_RST;
    end else if (cfg_we) begin
      unique case (bdc_pkg::cfg_idx_t'(cfg_index))
        bdc_pkg::CFG_PRESS_POL:  press_pol_r       <= cfg_wdata[0];
        bdc_pkg::CFG_DEBOUNCE:   debounce_time_r   <= cfg_wdata;
        bdc_pkg::CFG_LONG_PRESS: long_press_time_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_level_r <= in_pin_level;
      s1_time_r  <= in_time_now;
    end
  end

  bdc_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (fire),
    .pin_level       (s1_level_r),
    .time_now        (s1_time_r),
    .press_pol       (press_pol_r),
    .debounce_time   (debounce_time_r),
    .long_press_time (long_press_time_r),
    .event_code      (evt),
    .status          (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_event_r <= evt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_code = out_event_r;

  `ASSERT_NEXT(a_fire_gives_result, clk, rst_n, fire, out_valid_r)
  `ASSERT_NEXT(a_long_disarms, clk, rst_n, fire && (evt == bdc_pkg::EV_LONG), !status.armed)
  `ASSERT_NEXT(a_press_arms, clk, rst_n,
    fire && !status.pressed && (s1_level_r == press_pol_r),
    status.pressed && status.armed)
  `ASSERT_SAME(a_result_from_pressed, clk, rst_n,
    fire && ((evt == bdc_pkg::EV_LONG) || (evt == bdc_pkg::EV_CLICK) ||
             (evt == bdc_pkg::EV_ACTIVE)),
    status.pressed)

endmodule
`default_nettype wire
